[design/sfe_pkg.sv]
// shared types, constants and codes for the serial frame endpoint
// no dependencies; used by every module of the block
package sfe_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int FRAME_OVERHEAD  = 8;
  localparam int SHORT_LIMIT     = 8;
  localparam int MAX_BODY        = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int NUM_BYTES       = 7;

  localparam logic [15:0] MAX_PLEN    = 16'(MAX_BODY);
  localparam logic [16:0] MAX_FLEN    = 17'(MAX_BODY);
  localparam logic [16:0] SHORT_FLEN  = 17'(SHORT_LIMIT);
  localparam logic [15:0] HDR_WINDOW  = 16'd8;

  localparam logic [2:0] CFG_HEADER  = 3'd0;
  localparam logic [2:0] CFG_VERSION = 3'd1;
  localparam logic [2:0] CFG_NORMAL  = 3'd2;
  localparam logic [2:0] CFG_ACK     = 3'd3;
  localparam logic [2:0] CFG_ERROR   = 3'd4;

  localparam logic [1:0] FUNC_TX_START   = 2'd0;
  localparam logic [1:0] FUNC_TX_PAYLOAD = 2'd1;
  localparam logic [1:0] FUNC_RX_BYTE    = 2'd2;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [2:0] ST_NORMAL  = 3'd0;
  localparam logic [2:0] ST_ACK     = 3'd1;
  localparam logic [2:0] ST_ERROR   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_BAD_SUM = 3'd4;
  localparam logic [2:0] ST_DROPPED = 3'd5;
  localparam logic [2:0] ST_SHORT   = 3'd6;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] version_byte;
    logic [7:0] normal_type_code;
    logic [7:0] ack_type_code;
    logic [7:0] error_type_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        end_of_frame;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
  } item_t;

  typedef struct packed {
    logic                          has_report;
    logic [2:0]                    rx_status;
    logic [7:0]                    rx_seq;
    logic [7:0]                    rx_type;
    logic [15:0]                   rx_command;
    logic [15:0]                   rx_length_field;
    logic [2:0]                    num_bytes;
    logic [NUM_BYTES-1:0][7:0]     bytes;
  } burst_t;

endpackage

[design/sfe_cfg.sv]
// configuration register file of the serial frame endpoint
// depends on sfe_pkg
module sfe_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [7:0]    cfg_wdata,
  output sfe_pkg::cfg_t cfg
);

  sfe_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte      <= 8'd170;
      cfg_r.version_byte     <= 8'd1;
      cfg_r.normal_type_code <= 8'd0;
      cfg_r.ack_type_code    <= 8'd1;
      cfg_r.error_type_code  <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sfe_pkg::CFG_HEADER:  cfg_r.header_byte      <= cfg_wdata;
        sfe_pkg::CFG_VERSION: cfg_r.version_byte     <= cfg_wdata;
        sfe_pkg::CFG_NORMAL:  cfg_r.normal_type_code <= cfg_wdata;
        sfe_pkg::CFG_ACK:     cfg_r.ack_type_code    <= cfg_wdata;
        sfe_pkg::CFG_ERROR:   cfg_r.error_type_code  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/sfe_core.sv]
// frame state and per-transaction result computation
// depends on sfe_pkg; feeds the output serializer sfe_outq
module sfe_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  sfe_pkg::item_t  item,
  input  sfe_pkg::cfg_t   cfg,
  output sfe_pkg::burst_t burst
);

  logic [7:0]       send_seq_r, send_seq_nxt;
  logic             tx_active_r, tx_active_nxt;
  logic [15:0]      tx_remaining_r, tx_remaining_nxt;
  logic [7:0]       tx_sum_r, tx_sum_nxt;
  logic [15:0]      rx_count_r, rx_count_nxt;
  logic [7:0]       rx_sum_r, rx_sum_nxt;
  logic [7:0][7:0]  rx_hdr_r, rx_hdr_nxt;

  logic [7:0]       start_sum;
  logic [15:0]      rem_dec;
  logic [7:0]       pay_sum;
  logic [7:0][7:0]  hdr_cur;
  logic [16:0]      flen;
  logic [7:0]       reply_seq;
  logic [7:0]       reply_type;
  logic [7:0]       reply_sum;
  logic             reply;
  logic [2:0]       status;

  always_comb begin
    send_seq_nxt     = send_seq_r;
    tx_active_nxt    = tx_active_r;
    tx_remaining_nxt = tx_remaining_r;
    tx_sum_nxt       = tx_sum_r;
    rx_count_nxt     = rx_count_r;
    rx_sum_nxt       = rx_sum_r;
    rx_hdr_nxt       = rx_hdr_r;
    burst            = '0;

    start_sum = cfg.header_byte + cfg.version_byte + item.frame_seq + item.frame_type
              + item.payload_length[15:8] + item.payload_length[7:0];
    rem_dec   = tx_remaining_r - 16'd1;
    pay_sum   = tx_sum_r + item.data_byte;

    hdr_cur = rx_hdr_r;
    if (rx_count_r < sfe_pkg::HDR_WINDOW) begin
      hdr_cur[rx_count_r[2:0]] = rx_hdr_r[rx_count_r[2:0]] | item.data_byte;
    end
    flen = {1'b0, rx_count_r} + 17'd1;

    reply      = 1'b0;
    reply_seq  = send_seq_r;
    reply_type = cfg.error_type_code;
    if ((hdr_cur[0] != cfg.header_byte) || (flen > sfe_pkg::MAX_FLEN)) begin
      status = sfe_pkg::ST_DROPPED;
    end else if (flen < sfe_pkg::SHORT_FLEN) begin
      status = sfe_pkg::ST_SHORT;
    end else if (rx_sum_r != item.data_byte) begin
      status = sfe_pkg::ST_BAD_SUM;
      reply  = 1'b1;
    end else if (hdr_cur[3] == cfg.normal_type_code) begin
      status     = sfe_pkg::ST_NORMAL;
      reply      = 1'b1;
      reply_seq  = hdr_cur[2];
      reply_type = cfg.ack_type_code;
    end else if (hdr_cur[3] == cfg.ack_type_code) begin
      status = sfe_pkg::ST_ACK;
    end else if (hdr_cur[3] == cfg.error_type_code) begin
      status = sfe_pkg::ST_ERROR;
    end else begin
      status = sfe_pkg::ST_UNKNOWN;
    end
    reply_sum = cfg.header_byte + cfg.version_byte + reply_seq + reply_type;

    unique case (item.func)
      sfe_pkg::FUNC_TX_START: begin
        tx_active_nxt    = 1'b0;
        tx_remaining_nxt = '0;
        if (item.payload_length <= sfe_pkg::MAX_PLEN) begin
          tx_sum_nxt     = start_sum;
          burst.bytes[0] = cfg.header_byte;
          burst.bytes[1] = cfg.version_byte;
          burst.bytes[2] = item.frame_seq;
          burst.bytes[3] = item.frame_type;
          burst.bytes[4] = item.payload_length[15:8];
          burst.bytes[5] = item.payload_length[7:0];
          burst.bytes[6] = start_sum;
          if (item.payload_length == 16'd0) begin
            burst.num_bytes = 3'd7;
            send_seq_nxt    = send_seq_r + 8'd1;
          end else begin
            burst.num_bytes  = 3'd6;
            tx_active_nxt    = 1'b1;
            tx_remaining_nxt = item.payload_length;
          end
        end
      end
      sfe_pkg::FUNC_TX_PAYLOAD: begin
        if (tx_active_r) begin
          burst.bytes[0]   = item.data_byte;
          burst.bytes[1]   = pay_sum;
          burst.num_bytes  = 3'd1;
          tx_sum_nxt       = pay_sum;
          tx_remaining_nxt = rem_dec;
          if (rem_dec == 16'd0) begin
            burst.num_bytes = 3'd2;
            tx_active_nxt   = 1'b0;
            send_seq_nxt    = send_seq_r + 8'd1;
          end
        end
      end
      sfe_pkg::FUNC_RX_BYTE: begin
        rx_hdr_nxt = hdr_cur;
        if (!item.end_of_frame) begin
          rx_sum_nxt = rx_sum_r + item.data_byte;
          if (rx_count_r != 16'hFFFF) begin
            rx_count_nxt = rx_count_r + 16'd1;
          end
        end else begin
          burst.has_report      = 1'b1;
          burst.rx_status       = status;
          burst.rx_seq          = hdr_cur[2];
          burst.rx_type         = hdr_cur[3];
          burst.rx_command      = {hdr_cur[6], hdr_cur[7]};
          burst.rx_length_field = {hdr_cur[4], hdr_cur[5]};
          burst.bytes[0]        = cfg.header_byte;
          burst.bytes[1]        = cfg.version_byte;
          burst.bytes[2]        = reply_seq;
          burst.bytes[3]        = reply_type;
          burst.bytes[6]        = reply_sum;
          if (reply) begin
            burst.num_bytes = 3'd7;
            send_seq_nxt    = send_seq_r + 8'd1;
          end
          rx_count_nxt = '0;
          rx_sum_nxt   = '0;
          rx_hdr_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_seq_r     <= '0;
      tx_active_r    <= 1'b0;
      tx_remaining_r <= '0;
      tx_sum_r       <= '0;
      rx_count_r     <= '0;
      rx_sum_r       <= '0;
      rx_hdr_r       <= '0;
    end else if (step) begin
      send_seq_r     <= send_seq_nxt;
      tx_active_r    <= tx_active_nxt;
      tx_remaining_r <= tx_remaining_nxt;
      tx_sum_r       <= tx_sum_nxt;
      rx_count_r     <= rx_count_nxt;
      rx_sum_r       <= rx_sum_nxt;
      rx_hdr_r       <= rx_hdr_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_active_has_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    tx_active_r |-> (tx_remaining_r != 16'd0))
    else $error("transmit active with no payload left");

  a_report_clears_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (step && burst.has_report) |=> (rx_count_r == 16'd0 && rx_sum_r == 8'd0))
    else $error("receive state not cleared after frame end");

  a_seq_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (step && burst.num_bytes == 3'd7) |=> (send_seq_r == $past(send_seq_r) + 8'd1))
    else $error("sequence not advanced after complete frame");
`endif

endmodule

[design/sfe_outq.sv]
// result holding register and serializer, one result per output transaction
// depends on sfe_pkg; loaded by sfe_core results
module sfe_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  sfe_pkg::burst_t burst,
  output logic            load_ok,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic            out_tlast,
  output logic [0:0]      out_tuser,
  output logic [63:0]     out_tdata
);

  sfe_pkg::burst_t burst_r;
  logic            valid_r;
  logic [2:0]      pos_r;
  logic [3:0]      total;
  logic [3:0]      last_pos;
  logic            is_last;
  logic            is_report;
  logic [2:0]      bidx;
  logic            out_fire;
  logic [3:0]      load_total;

  assign total      = {3'b0, burst_r.has_report} + {1'b0, burst_r.num_bytes};
  assign last_pos   = total - 4'd1;
  assign is_last    = (pos_r == last_pos[2:0]);
  assign is_report  = burst_r.has_report && (pos_r == 3'd0);
  assign bidx       = pos_r - {2'b0, burst_r.has_report};
  assign out_fire   = valid_r && out_tready;
  assign load_ok    = !valid_r || (out_tready && is_last);
  assign load_total = {3'b0, burst.has_report} + {1'b0, burst.num_bytes};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else if (load) begin
      valid_r <= (load_total != 4'd0);
      pos_r   <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        valid_r <= 1'b0;
      end else begin
        pos_r <= pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst;
    end
  end

  always_comb begin
    out_tdata = '0;
    if (is_report) begin
      out_tuser       = sfe_pkg::KIND_REPORT;
      out_tdata[10:8]  = burst_r.rx_status;
      out_tdata[18:11] = burst_r.rx_seq;
      out_tdata[26:19] = burst_r.rx_type;
      out_tdata[42:27] = burst_r.rx_command;
      out_tdata[58:43] = burst_r.rx_length_field;
    end else begin
      out_tuser       = sfe_pkg::KIND_BYTE;
      out_tdata[7:0]  = burst_r.bytes[bidx];
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = is_last;

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ({1'b0, pos_r} <= last_pos))
    else $error("serializer position beyond held results");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && is_last && !load) |=> !valid_r)
    else $error("holding register still valid after last result");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (load && load_total != 4'd0) |=> (valid_r && pos_r == 3'd0))
    else $error("new results not presented from the start");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !(out_tready && is_last)) |-> !load)
    else $error("held results overwritten before delivery");
`endif

endmodule

[design/serial_frame_endpoint.sv]
// Serial frame endpoint: builds outgoing frames (header, payload pass-through, 8-bit sum),
// checks received frames and answers them with ack or error frames. An input transaction
// is registered in item_r, worked out combinationally and its results (up to eight) held
// in an output register that hands them out one per output transaction; the first result
// is offered once it has passed item_r and been loaded into that output register. A
// transaction with at most one result sustains one per cycle while out_tready is high;
// one with n results holds the output until all are taken, and the next transaction moves
// on in the cycle the last of them is taken. The output serializer sets the rate. Depends
// on sfe_pkg, sfe_cfg, sfe_core and sfe_outq.
module serial_frame_endpoint (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_byte, frame_seq, frame_type, payload_length
  input  logic        in_tlast,
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_byte, rx_status, rx_seq, rx_type, rx_command,
                                  // rx_length_field, zero fill
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  sfe_pkg::cfg_t   cfg;
  sfe_pkg::item_t  item_r;
  sfe_pkg::burst_t burst;
  logic            in_valid_r;
  logic            load_ok;
  logic            step;

  assign step      = in_valid_r && load_ok;
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func           <= in_tuser;
      item_r.data_byte      <= in_tdata[7:0];
      item_r.end_of_frame   <= in_tlast;
      item_r.frame_seq      <= in_tdata[15:8];
      item_r.frame_type     <= in_tdata[23:16];
      item_r.payload_length <= in_tdata[39:24];
    end
  end

  sfe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfe_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .burst (burst)
  );

  sfe_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .burst      (burst),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
